>>> rtl/core/dets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dets_pkg
// Types, codes and the key compare for the draw entry table sorter.
// ----------------------------------------------------------------------------
package dets_pkg;

  // request codes carried in in_tuser
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_SORT   = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned IN_DATA_W = 144;
  localparam int unsigned OUT_DATA_W = 144;
  localparam int unsigned CAP_W = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // sort key sits in the low 65 bits: {transparent, shader_id, mesh_id}
  typedef struct packed {
    logic [31:0] light_mask;
    logic [31:0] matrix_handle;
    logic [3:0]  mesh_kind;
    logic        transparent;
    logic [31:0] shader_id;
    logic [31:0] mesh_id;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctrl_t;

  // true when a must come strictly after b
  function automatic logic goes_after(entry_t a, entry_t b);
    logic [64:0] ka;
    logic [64:0] kb;
    ka = {a.transparent, a.shader_id, a.mesh_id};
    kb = {b.transparent, b.shader_id, b.mesh_id};
    return ka > kb;
  endfunction

endpackage

>>> rtl/core/dets_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dets_cell
// One slot of the insertion chain: keeps the smaller entry, passes the other.
// ----------------------------------------------------------------------------
module dets_cell
  import dets_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  chain_ctrl_t ctrl,
  input  logic        in_vld,
  input  entry_t      in_data,
  input  entry_t      right_data,
  output entry_t      held_data,
  output logic        pass_vld,
  output entry_t      pass_data
);

  logic   held_vld_r, held_vld_nxt;
  entry_t held_r, held_nxt;
  logic   pass_vld_r, pass_vld_nxt;
  entry_t pass_r, pass_nxt;
  logic   take;

  // an equal key takes the slot, so the passed stream keeps arrival order and
  // equal keys settle last arrival first; the table is fed last entry first
  always_comb begin
    take         = in_vld && (!held_vld_r || !goes_after(in_data, held_r));
    held_vld_nxt = held_vld_r || in_vld;
    pass_vld_nxt = in_vld && held_vld_r;
    pass_nxt     = take ? held_r : in_data;
    if (ctrl.shift) begin
      held_nxt = right_data;
    end else if (take) begin
      held_nxt = in_data;
    end else begin
      held_nxt = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else if (ctrl.clear) begin
      held_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else if (ctrl.shift) begin
      pass_vld_r <= 1'b0;
    end else begin
      held_vld_r <= held_vld_nxt;
      pass_vld_r <= pass_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    pass_r <= pass_nxt;
  end

  assign held_data = held_r;
  assign pass_vld  = pass_vld_r;
  assign pass_data = pass_r;

endmodule

>>> rtl/core/dets_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dets_chain
// Row of sorting cells; fed at the head, unloaded by shifting toward the head.
// ----------------------------------------------------------------------------
module dets_chain
  import dets_pkg::*;
#(
  parameter int unsigned N = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  chain_ctrl_t ctrl,
  input  logic        feed_vld,
  input  entry_t      feed_data,
  output entry_t      head_data
);

  logic   vld  [0:N];
  entry_t data [0:N];
  entry_t held [0:N];

  assign vld[0]  = feed_vld;
  assign data[0] = feed_data;
  assign held[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dets_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .in_vld     (vld[i]),
      .in_data    (data[i]),
      .right_data (held[i+1]),
      .held_data  (held[i]),
      .pass_vld   (vld[i+1]),
      .pass_data  (data[i+1])
    );
  end

  assign head_data = held[0];

endmodule

>>> rtl/core/draw_entry_table_key_sorter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// draw_entry_table_key_sorter_unit
// Table of deferred draw entries with insert, clear, stable key sort and read.
// ----------------------------------------------------------------------------
//
//  channel  | dir | ports                          | carries
//  ---------+-----+--------------------------------+---------------------------
//  in_      | in  | tvalid tready tdata tuser      | one request (action, entry)
//  out_     | out | tvalid tready tdata tuser      | one result per request
//  cfg_     | in  | psel penable pwrite paddr ...  | capacity register, addr 0
//
//  insert and clear load their result when the request is taken, read first
//  passes through the registered table memory read; sort streams the table
//  into the cell row, lets the row settle and shifts the sorted row back into
//  the table memory
//  synchronous active-low reset clears the entry count, the state and the
//  result valid flag; table contents are not cleared and need no pass
//  a stalled result holds in the output register; one new request is taken
//  in the cycle the held result leaves
//
module draw_entry_table_key_sorter_unit
  import dets_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // mesh_id[31:0] mesh_kind[35:32] shader_id[67:36] is_transparent[68]
  // matrix_handle[100:69] light_mask[132:101] entry_index[140:133]
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // action[1:0]
  input  logic [1:0]             in_tuser,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // entry_count[8:0] out_mesh_id[40:9] out_mesh_kind[44:41]
  // out_shader_id[76:45] out_transparent[77] out_matrix_handle[109:78]
  // out_light_mask[141:110]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // accepted[0] index_error[1]
  output logic [1:0]             out_tuser,
  // configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_FEED   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_UNLOAD = 3'd4;

  // ---------------------------------------------------------------- registers
  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic                  feed_vld_r, feed_vld_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [CAP_W-1:0]      capacity_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_user_r, out_user_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // table memory, one entry per word
  entry_t                mem [0:MAX_ENTRIES-1];
  entry_t                ram_q;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  entry_t                ram_wdata;

  // ------------------------------------------------------------ request decode
  logic                  in_acc;
  logic [1:0]            action;
  entry_t                in_entry;
  logic [7:0]            entry_index;
  logic [CW+8:0]         cnt_cap_w;
  logic [CW+8:0]         cap_w;
  logic [CW+7:0]         idx_w;
  logic [CW+7:0]         cnt_idx_w;
  logic                  can_insert;
  logic                  idx_ok;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign action    = in_tuser;

  assign in_entry.mesh_id       = in_tdata[31:0];
  assign in_entry.mesh_kind     = in_tdata[35:32];
  assign in_entry.shader_id     = in_tdata[67:36];
  assign in_entry.transparent   = in_tdata[68];
  assign in_entry.matrix_handle = in_tdata[100:69];
  assign in_entry.light_mask    = in_tdata[132:101];
  assign entry_index            = in_tdata[140:133];

  // limit is the smaller of capacity and the table depth
  assign cnt_cap_w  = {9'd0, count_r};
  assign cap_w      = {{CW{1'b0}}, capacity_r};
  assign can_insert = (cnt_cap_w < cap_w) && (count_r < MAX_C);

  // count never exceeds the depth, so a hit also lies inside the table
  assign idx_w     = {{CW{1'b0}}, entry_index};
  assign cnt_idx_w = {8'd0, count_r};
  assign idx_ok    = idx_w < cnt_idx_w;

  // ---------------------------------------------------------------- cell row
  chain_ctrl_t chain_ctrl;
  entry_t      head_data;

  dets_chain #(
    .N (MAX_ENTRIES)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (chain_ctrl),
    .feed_vld  (feed_vld_r),
    .feed_data (ram_q),
    .head_data (head_data)
  );

  // ---------------------------------------------------------------- control
  logic          res_load;
  logic          res_ok;
  logic          res_err;
  entry_t        res_entry;
  logic [CW+8:0] cnt_out_w;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    feed_vld_nxt  = 1'b0;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = in_entry;
    ram_raddr     = idx_w[AW-1:0];
    chain_ctrl    = '0;
    res_load      = 1'b0;
    res_ok        = 1'b0;
    res_err       = 1'b0;
    res_entry     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (action)
            ACT_INSERT: begin
              res_load = 1'b1;
              if (can_insert) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                res_ok    = 1'b1;
              end
            end
            ACT_CLEAR: begin
              count_nxt = '0;
              res_load  = 1'b1;
              res_ok    = 1'b1;
            end
            ACT_SORT: begin
              // zero or one entry is already in order
              if (count_r < CW'(2)) begin
                res_load = 1'b1;
                res_ok   = 1'b1;
              end else begin
                chain_ctrl.clear = 1'b1;
                k_nxt            = count_r - CW'(1);
                state_nxt        = ST_FEED;
              end
            end
            ACT_READ: begin
              rd_ok_nxt = idx_ok;
              state_nxt = ST_READ;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load  = 1'b1;
        res_ok    = rd_ok_r;
        res_err   = !rd_ok_r;
        res_entry = rd_ok_r ? ram_q : '0;
        state_nxt = ST_IDLE;
      end
      ST_FEED: begin
        // stream the table into the head cell, last entry first, one a cycle
        ram_raddr    = k_r[AW-1:0];
        feed_vld_nxt = 1'b1;
        if (k_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r - CW'(1);
        end
      end
      ST_DRAIN: begin
        // displaced entries travel at most count cells
        if (k_r == count_r) begin
          k_nxt     = '0;
          state_nxt = ST_UNLOAD;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      ST_UNLOAD: begin
        chain_ctrl.shift = 1'b1;
        ram_we           = 1'b1;
        ram_waddr        = k_r[AW-1:0];
        ram_wdata        = head_data;
        if (k_r == count_r - CW'(1)) begin
          res_load  = 1'b1;
          res_ok    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    cnt_out_w = {9'd0, count_nxt};
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = {res_err, res_ok};
      out_data_nxt  = {2'b00, res_entry.light_mask, res_entry.matrix_handle,
                       res_entry.transparent, res_entry.shader_id,
                       res_entry.mesh_kind, res_entry.mesh_id,
                       cnt_out_w[CNT_OUT_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      feed_vld_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      feed_vld_r  <= feed_vld_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[ram_waddr] <= ram_wdata;
    end
    ram_q <= mem[ram_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- config
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-CAP_W){1'b0}}, capacity_r};

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("entry count beyond table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (action == ACT_INSERT) && can_insert |=>
      count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the table");

  a_sort_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FEED) || (state_r == ST_DRAIN) || (state_r == ST_UNLOAD) |=>
      count_r == $past(count_r))
    else $error("entry count changed during sort");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !(out_valid_r && !out_tready))
    else $error("request taken while a result is stalled");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the draw entry table key sorter. Streams insert,
// clear, sort and read requests under several capacity settings and idle
// patterns, predicts each result from a local copy of the table and compares
// every result field by field.
// ----------------------------------------------------------------------------
module testbench
  import dets_pkg::*;
;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam logic [2:0]  REG_CAPACITY = 3'd0;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          CYCLE_LIMIT = 5_000_000;

  // one predicted result
  typedef struct packed {
    logic       accepted;
    logic       index_error;
    logic [8:0] count;
    entry_t     item;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // mesh_id, mesh_kind, shader_id, is_transparent, matrix_handle, light_mask,
  // entry_index, zero fill
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // action
  logic [1:0]            in_tuser = ACT_INSERT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // entry_count, out_mesh_id, out_mesh_kind, out_shader_id, out_transparent,
  // out_matrix_handle, out_light_mask, zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  // accepted, index_error
  logic [1:0]            out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [2:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // local copy of the table and its settings
  entry_t     draw_table [TABLE_DEPTH];
  int         entry_total = 0;
  int         cap_setting = 256;
  outcome_t   pending_results[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         cycle_count = 0;

  draw_entry_table_key_sorter_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // run limit, far above the slowest legal run (full-table sorts included)
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // table predictor
  // ---------------------------------------------------------------------------

  // opaque first, then shader id, then mesh id, all ascending
  function automatic logic sorts_later(entry_t a, entry_t b);
    if (a.transparent != b.transparent) return a.transparent;
    if (a.shader_id != b.shader_id) return a.shader_id > b.shader_id;
    return a.mesh_id > b.mesh_id;
  endfunction

  // insertion sort keeps equal keys in arrival order
  function automatic void sort_draw_table();
    entry_t held;
    int     j;
    for (int i = 1; i < entry_total; i++) begin
      held = draw_table[i];
      j = i;
      while (j > 0 && sorts_later(draw_table[j-1], held)) begin
        draw_table[j] = draw_table[j-1];
        j--;
      end
      draw_table[j] = held;
    end
  endfunction

  // apply one accepted request and queue the result it must produce
  function automatic void predict_request(logic [1:0] act, entry_t e, logic [7:0] idx);
    outcome_t r;
    int       limit;
    r = '0;
    limit = (cap_setting > TABLE_DEPTH) ? TABLE_DEPTH : cap_setting;
    case (act)
      ACT_INSERT: begin
        // dropped once the table reaches the capacity
        if (entry_total < limit) begin
          draw_table[entry_total] = e;
          entry_total++;
          r.accepted = 1'b1;
        end
      end
      ACT_CLEAR: begin
        entry_total = 0;
        r.accepted = 1'b1;
      end
      ACT_SORT: begin
        sort_draw_table();
        r.accepted = 1'b1;
      end
      default: begin
        if (int'(idx) < entry_total) begin
          r.accepted = 1'b1;
          r.item = draw_table[idx];
        end else begin
          r.index_error = 1'b1;
        end
      end
    endcase
    r.count = entry_total[8:0];
    pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // sample mid-cycle, where the handshake signals are settled
  always @(negedge clk) begin : check_result
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request waiting for it");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_tuser[0]));
        check_field("index_error", 32'(want.index_error), 32'(out_tuser[1]));
        check_field("entry_count", 32'(want.count), 32'(out_tdata[8:0]));
        check_field("out_mesh_id", want.item.mesh_id, out_tdata[40:9]);
        check_field("out_mesh_kind", 32'(want.item.mesh_kind), 32'(out_tdata[44:41]));
        check_field("out_shader_id", want.item.shader_id, out_tdata[76:45]);
        check_field("out_transparent", 32'(want.item.transparent), 32'(out_tdata[77]));
        check_field("out_matrix_handle", want.item.matrix_handle, out_tdata[109:78]);
        check_field("out_light_mask", want.item.light_mask, out_tdata[141:110]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one request: random gap, then hold until the handshake edge
  task automatic send_request(input logic [1:0] act, input entry_t e, input logic [7:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, idx, e.light_mask, e.matrix_handle, e.transparent,
                  e.shader_id, e.mesh_kind, e.mesh_id};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    predict_request(act, e, idx);
  endtask

  // stop sending and let every queued result drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, then read back over the same port
  task automatic write_capacity(input logic [8:0] value);
    logic [31:0] readback;
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_CAPACITY;
    cfg_pwdata  <= {23'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cap_setting = int'(value);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    readback = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field("capacity", {23'd0, value}, readback);
  endtask

  function automatic entry_t make_entry(logic [31:0] mesh, logic [3:0] kind,
                                        logic [31:0] shader, logic transp,
                                        logic [31:0] matrix, logic [31:0] light);
    entry_t e;
    e.mesh_id       = mesh;
    e.mesh_kind     = kind;
    e.shader_id     = shader;
    e.transparent   = transp;
    e.matrix_handle = matrix;
    e.light_mask    = light;
    return e;
  endfunction

  // key words from a narrow pool so ties are frequent, plus full range
  function automatic logic [31:0] pick_key_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic entry_t random_entry();
    return make_entry(pick_key_word(), 4'($urandom_range(0, 15)), pick_key_word(),
                      1'($urandom_range(0, 1)), $urandom, $urandom);
  endfunction

  // read index: mostly a stored entry, sometimes past the end
  function automatic logic [7:0] pick_read_index();
    if (entry_total > 0 && $urandom_range(0, 4) != 0)
      return 8'($urandom_range(0, entry_total - 1));
    if (entry_total < TABLE_DEPTH)
      return 8'($urandom_range(entry_total, TABLE_DEPTH - 1));
    return 8'($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes of every field, every action, ties and out-of-range reads
  task automatic test_directed_ops();
    entry_t none;
    none = '0;
    write_capacity(9'd256);
    send_request(ACT_READ, none, 8'd0);        // empty table read
    send_request(ACT_SORT, none, 8'd0);        // empty table sort
    send_request(ACT_INSERT, make_entry('1, 4'hF, '1, 1'b1, '1, '1), 8'd0);
    send_request(ACT_INSERT, make_entry('0, 4'h0, '0, 1'b0, '0, '0), 8'd0);
    send_request(ACT_INSERT, make_entry(32'h5, 4'h3, 32'h0, 1'b1, 32'h11, 32'h22), 8'd0);
    send_request(ACT_INSERT, make_entry(32'h9, 4'h7, '1, 1'b0, 32'h33, 32'h44), 8'd0);
    // equal keys with distinct payload, order must survive the sort
    send_request(ACT_INSERT, make_entry(32'h7, 4'h1, 32'h40, 1'b0, 32'hA1, 32'hB1), 8'd0);
    send_request(ACT_INSERT, make_entry(32'h7, 4'h2, 32'h40, 1'b0, 32'hA2, 32'hB2), 8'd0);
    send_request(ACT_READ, none, 8'd0);
    send_request(ACT_READ, none, 8'd255);      // index far past the count
    send_request(ACT_READ, none, 8'd6);        // index equal to the count
    send_request(ACT_SORT, none, 8'd0);
    for (int i = 0; i < 6; i++) send_request(ACT_READ, none, i[7:0]);
    send_request(ACT_CLEAR, none, 8'd0);
    send_request(ACT_READ, none, 8'd0);
  endtask

  // capacity limit, capacity below count, capacity zero and a full table
  task automatic test_capacity_limits();
    entry_t none;
    none = '0;
    write_capacity(9'd1);
    send_request(ACT_CLEAR, none, 8'd0);
    send_request(ACT_INSERT, random_entry(), 8'd0);
    send_request(ACT_INSERT, random_entry(), 8'd0);   // dropped
    send_request(ACT_READ, none, 8'd0);
    send_request(ACT_READ, none, 8'd1);
    write_capacity(9'd256);
    send_request(ACT_INSERT, random_entry(), 8'd0);
    send_request(ACT_INSERT, random_entry(), 8'd0);
    // shrink below the stored count: entries stay, inserts drop
    write_capacity(9'd2);
    send_request(ACT_INSERT, random_entry(), 8'd0);
    send_request(ACT_READ, none, 8'd2);
    send_request(ACT_SORT, none, 8'd0);
    send_request(ACT_READ, none, 8'd2);
    write_capacity(9'd0);
    send_request(ACT_CLEAR, none, 8'd0);
    send_request(ACT_INSERT, random_entry(), 8'd0);
    send_request(ACT_READ, none, 8'd0);
    // fill the whole table, one more insert overflows
    write_capacity(9'd256);
    send_request(ACT_CLEAR, none, 8'd0);
    for (int i = 0; i <= TABLE_DEPTH; i++) send_request(ACT_INSERT, random_entry(), 8'd0);
    send_request(ACT_SORT, none, 8'd0);
    send_request(ACT_READ, none, 8'd255);
    for (int i = 0; i < 8; i++) send_request(ACT_READ, none, pick_read_index());
    send_request(ACT_CLEAR, none, 8'd0);
  endtask

  // frames of clear, inserts, sort and reads with random content and noise
  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct, input logic [8:0] cap);
    int sent;
    int batch;
    entry_t none;
    none = '0;
    sent = 0;
    write_capacity(cap);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        // noise: any action with any field values
        send_request(2'($urandom_range(0, 3)), random_entry(), 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_request(ACT_CLEAR, none, 8'd0);
          sent++;
        end
        // now and then a batch large enough to hit the capacity
        batch = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 260) : $urandom_range(0, 12);
        for (int i = 0; i < batch; i++) begin
          send_request(ACT_INSERT, random_entry(), 8'd0);
          if ($urandom_range(0, 7) == 0) begin
            send_request(ACT_READ, none, pick_read_index());
            sent++;
          end
        end
        sent += batch;
        // broken frame: sometimes no sort before the reads
        if ($urandom_range(0, 9) != 0) begin
          send_request(ACT_SORT, none, 8'd0);
          sent++;
        end
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          send_request(ACT_READ, none, pick_read_index());
          sent++;
        end
        // hold off until the block has answered everything
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    send_idle_pct = 6;
    recv_idle_pct = 87;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_capacity_limits();
    test_random_traffic(560, 6, 87, 9'd256);
    test_random_traffic(560, 87, 6, 9'($urandom_range(3, 40)));
    test_random_traffic(560, 0, 0, 9'd255);
    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
